// File: rtl/ccs_pkg.sv
// shared types and constants for the chat control code stripper
`default_nettype none

package ccs_pkg;

  // input request: one character of a text line
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } ccs_in_t;

  // result: the character, its keep flag and the line end mark
  typedef struct packed {
    logic       keep;
    logic [7:0] out_byte;
    logic       out_last;
  } ccs_out_t;

  // position inside a color code, one-hot
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_FG0  = 6'b000010,
    PH_FG1  = 6'b000100,
    PH_FG2  = 6'b001000,
    PH_BG0  = 6'b010000,
    PH_BG1  = 6'b100000
  } ccs_phase_e;

  // character codes
  localparam logic [7:0] CH_SOH   = 8'd1;
  localparam logic [7:0] CH_BOLD  = 8'd2;
  localparam logic [7:0] CH_COLOR = 8'd3;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_REV   = 8'd22;
  localparam logic [7:0] CH_UNDER = 8'd31;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // bytes that are always dropped outside a color code
  function automatic logic is_ctrl(input logic [7:0] b);
    is_ctrl = (b == CH_SOH) || (b == CH_BOLD) || (b == CH_COLOR) || (b == CH_TAB)
           || (b == CH_LF) || (b == CH_CR) || (b == CH_REV) || (b == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: rtl/chat_control_code_stripper.sv
// A request is captured in the input register and then moves into the output register; an output stall holds it.
// Throughput: one character per cycle while out_stall_i is low; the color phase register is the
// only loop.
// Reset: rst_ni clears both valid flags and returns the color phase to idle; payload
// registers are not reset.
`default_nettype none

module chat_control_code_stripper (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ccs_pkg::ccs_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ccs_pkg::ccs_out_t    out_data_o
);
  import ccs_pkg::*;

  logic       in_valid_q;
  ccs_in_t    in_data_q;
  logic       out_valid_q;
  ccs_out_t   out_data_q;
  ccs_out_t   out_data_d;
  ccs_phase_e phase_q;
  ccs_phase_e phase_d;
  ccs_phase_e next_ph;
  logic       absorbed;
  logic       out_adv;
  logic       in_adv;
  logic       dig;
  logic       comma;

  // pipeline flow control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // color code tracking
  assign dig   = is_digit(in_data_q.in_byte);
  assign comma = (in_data_q.in_byte == CH_COMMA);

  always_comb begin
    next_ph  = PH_IDLE;
    absorbed = 1'b0;
    case (phase_q)
      PH_FG0: begin
        if (dig) begin
          next_ph  = PH_FG1;
          absorbed = 1'b1;
        end
      end
      PH_FG1: begin
        if (dig) begin
          next_ph  = PH_FG2;
          absorbed = 1'b1;
        end else if (comma) begin
          next_ph  = PH_BG0;
          absorbed = 1'b1;
        end
      end
      PH_FG2: begin
        if (comma) begin
          next_ph  = PH_BG0;
          absorbed = 1'b1;
        end
      end
      PH_BG0: begin
        if (dig) begin
          next_ph  = PH_BG1;
          absorbed = 1'b1;
        end
      end
      PH_BG1: begin
        if (dig) begin
          absorbed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // a byte outside the code is judged plainly, byte 3 opens a new code
    if (!absorbed && (in_data_q.in_byte == CH_COLOR)) begin
      next_ph = PH_FG0;
    end
    phase_d = in_data_q.in_last ? PH_IDLE : next_ph;

    out_data_d.keep     = !absorbed && !is_ctrl(in_data_q.in_byte);
    out_data_d.out_byte = in_data_q.in_byte;
    out_data_d.out_last = in_data_q.in_last;
  end

  // phase and output registers advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/ccs_checker.sv
// port-level checks for the chat control code stripper, with its bind
`default_nettype none

module ccs_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire ccs_pkg::ccs_out_t out_data_o
);
  import ccs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // control bytes never pass
  a_ctrl_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_ctrl(out_data_o.out_byte) |-> !out_data_o.keep)
    else $error("control byte kept");

  // an empty output register never blocks a request
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output");

  // a request accepted while the output register is empty passes the input register and reaches the output side
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted request lost");

endmodule

bind chat_control_code_stripper ccs_checker u_ccs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
